// ===== hdl/sutq_pkg.sv =====
// shared types and constants of the sorted unique timestamp queue
package sutq_pkg;

  // default number of entries held
  localparam int unsigned CAPACITY_DEF = 16;

  // field widths
  localparam int unsigned TS_W     = 64;
  localparam int unsigned ACTION_W = 2;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned COUNT_W  = 5;

  // packed output data: popped, head, empty flag, count, padded to bytes
  localparam int unsigned OUT_FIELDS_W = 2 * TS_W + 1 + COUNT_W;
  localparam int unsigned OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;

  // action codes carried in in_tuser
  typedef enum logic [ACTION_W-1:0] {
    ACT_INSERT = 2'd0,
    ACT_POP    = 2'd1,
    ACT_CLEAR  = 2'd2,
    ACT_CLEAR2 = 2'd3
  } action_t;

  // result status codes carried in out_tuser
  typedef enum logic [STATUS_W-1:0] {
    ST_INSERTED  = 3'd0,
    ST_DUPLICATE = 3'd1,
    ST_FULL      = 3'd2,
    ST_POPPED    = 3'd3,
    ST_POP_EMPTY = 3'd4,
    ST_CLEARED   = 3'd5
  } status_t;

  // sequencer states, one-hot
  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_SCAN  = 6'b000010,
    S_SHIFT = 6'b000100,
    S_TAIL  = 6'b001000,
    S_POP   = 6'b010000,
    S_RES   = 6'b100000
  } state_t;

endpackage

// ===== hdl/sorted_unique_timestamp_queue_top.sv =====
// sorted unique timestamp queue: ordered set of distinct signed timestamps
//
//  channel | dir | tdata                    | tuser
//  --------+-----+--------------------------+-----------------
//  in_     | in  | timestamp[63:0]          | action[1:0]
//  out_    | out | popped, head, empty, cnt | status[2:0]
//
// insert walks the entries one per cycle through the single ram read port.
// pop moves every entry down one place.
// reset empties the set at once; the ram contents are left as they are.
// a finished result sits in the output register while the next item is
// accepted; a new result waits in the result state until that register frees.
module sorted_unique_timestamp_queue_top #(
  parameter int unsigned CAPACITY = sutq_pkg::CAPACITY_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // input channel
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [sutq_pkg::TS_W-1:0]       in_tdata,   // timestamp[63:0]
  input  logic [sutq_pkg::ACTION_W-1:0]   in_tuser,   // action[1:0]
  // result channel
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // popped_value[63:0], head_value[127:64], set_empty[128],
  // entry_count[133:129], zero[135:134]
  output logic [sutq_pkg::OUT_DATA_W-1:0] out_tdata,
  output logic [sutq_pkg::STATUS_W-1:0]   out_tuser   // status[2:0]
);

  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned TW = sutq_pkg::TS_W;
  localparam logic [CW-1:0] FULL_CNT = CW'(CAPACITY);

  sutq_pkg::state_t  state_r, state_nxt;
  sutq_pkg::status_t status_r, status_nxt;
  logic [CW-1:0]     idx_r, idx_nxt;
  logic [CW-1:0]     occ_r, occ_nxt;
  logic [TW-1:0]     head_r, head_nxt;
  logic [TW-1:0]     carry_r, carry_nxt;
  logic [TW-1:0]     popped_r, popped_nxt;

  logic                           out_valid_r, out_valid_nxt;
  logic [sutq_pkg::OUT_DATA_W-1:0] out_data_r, out_data_nxt;
  sutq_pkg::status_t              out_status_r, out_status_nxt;

  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [TW-1:0] wr_data;
  logic [TW-1:0] rd_data;

  logic [CW-1:0] idx_inc;
  logic          last;
  logic          full;
  logic          ge;
  logic          load_out;
  logic [TW-1:0] head_out;

  sutq_pkg::action_t action;

  assign action  = sutq_pkg::action_t'(in_tuser);
  assign idx_inc = idx_r + 1'b1;
  assign last    = (idx_inc == occ_r);
  assign full    = (occ_r == FULL_CNT);
  assign ge      = ($signed(rd_data) >= $signed(carry_r));

  // entry store
  sutq_ram #(
    .WIDTH (TW),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (idx_nxt[AW-1:0]),
    .rd_data (rd_data)
  );

  // sequencer
  always_comb begin
    state_nxt  = state_r;
    status_nxt = status_r;
    idx_nxt    = idx_r;
    occ_nxt    = occ_r;
    head_nxt   = head_r;
    carry_nxt  = carry_r;
    popped_nxt = popped_r;
    wr_en      = 1'b0;
    wr_addr    = idx_r[AW-1:0];
    wr_data    = carry_r;
    load_out   = 1'b0;
    case (state_r)
      sutq_pkg::S_IDLE: begin
        if (in_tvalid) begin
          popped_nxt = '0;
          case (action)
            sutq_pkg::ACT_INSERT: begin
              carry_nxt = in_tdata;
              if (occ_r == '0) begin
                wr_en      = 1'b1;
                wr_addr    = '0;
                wr_data    = in_tdata;
                head_nxt   = in_tdata;
                occ_nxt    = CW'(1);
                status_nxt = sutq_pkg::ST_INSERTED;
                state_nxt  = sutq_pkg::S_RES;
              end else begin
                idx_nxt   = '0;
                state_nxt = sutq_pkg::S_SCAN;
              end
            end
            sutq_pkg::ACT_POP: begin
              if (occ_r == '0) begin
                status_nxt = sutq_pkg::ST_POP_EMPTY;
                state_nxt  = sutq_pkg::S_RES;
              end else begin
                popped_nxt = head_r;
                status_nxt = sutq_pkg::ST_POPPED;
                if (occ_r == CW'(1)) begin
                  occ_nxt   = '0;
                  state_nxt = sutq_pkg::S_RES;
                end else begin
                  idx_nxt   = CW'(1);
                  state_nxt = sutq_pkg::S_POP;
                end
              end
            end
            default: begin
              occ_nxt    = '0;
              status_nxt = sutq_pkg::ST_CLEARED;
              state_nxt  = sutq_pkg::S_RES;
            end
          endcase
        end
      end
      // look for the first entry not below the new value
      sutq_pkg::S_SCAN: begin
        if (ge) begin
          if (rd_data == carry_r) begin
            status_nxt = sutq_pkg::ST_DUPLICATE;
            state_nxt  = sutq_pkg::S_RES;
          end else if (full) begin
            status_nxt = sutq_pkg::ST_FULL;
            state_nxt  = sutq_pkg::S_RES;
          end else begin
            wr_en     = 1'b1;
            carry_nxt = rd_data;
            if (idx_r == '0) begin
              head_nxt = carry_r;
            end
            idx_nxt   = idx_inc;
            state_nxt = last ? sutq_pkg::S_TAIL : sutq_pkg::S_SHIFT;
          end
        end else if (last) begin
          if (full) begin
            status_nxt = sutq_pkg::ST_FULL;
          end else begin
            wr_en      = 1'b1;
            wr_addr    = idx_inc[AW-1:0];
            occ_nxt    = occ_r + 1'b1;
            status_nxt = sutq_pkg::ST_INSERTED;
          end
          state_nxt = sutq_pkg::S_RES;
        end else begin
          idx_nxt = idx_inc;
        end
      end
      // move the remaining entries up one place
      sutq_pkg::S_SHIFT: begin
        wr_en     = 1'b1;
        carry_nxt = rd_data;
        idx_nxt   = idx_inc;
        if (last) begin
          state_nxt = sutq_pkg::S_TAIL;
        end
      end
      // last displaced entry goes to the new top slot
      sutq_pkg::S_TAIL: begin
        wr_en      = 1'b1;
        occ_nxt    = occ_r + 1'b1;
        status_nxt = sutq_pkg::ST_INSERTED;
        state_nxt  = sutq_pkg::S_RES;
      end
      // move every entry down one place after removing the minimum
      sutq_pkg::S_POP: begin
        wr_en   = 1'b1;
        wr_addr = AW'(idx_r - 1'b1);
        wr_data = rd_data;
        if (idx_r == CW'(1)) begin
          head_nxt = rd_data;
        end
        if (last) begin
          occ_nxt   = occ_r - 1'b1;
          state_nxt = sutq_pkg::S_RES;
        end else begin
          idx_nxt = idx_inc;
        end
      end
      sutq_pkg::S_RES: begin
        if (!out_valid_r || out_tready) begin
          load_out  = 1'b1;
          state_nxt = sutq_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = sutq_pkg::S_IDLE;
      end
    endcase
  end

  // result register
  assign head_out = (occ_r != '0) ? head_r : '0;

  always_comb begin
    out_valid_nxt  = out_valid_r && !out_tready;
    out_data_nxt   = out_data_r;
    out_status_nxt = out_status_r;
    if (load_out) begin
      out_valid_nxt  = 1'b1;
      out_status_nxt = status_r;
      out_data_nxt   = '0;
      out_data_nxt[TW-1:0]                   = popped_r;
      out_data_nxt[2*TW-1:TW]                = head_out;
      out_data_nxt[2*TW]                     = (occ_r == '0);
      out_data_nxt[2*TW+sutq_pkg::COUNT_W:2*TW+1] = sutq_pkg::COUNT_W'(occ_r);
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= sutq_pkg::S_IDLE;
      occ_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      occ_r       <= occ_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // working and payload registers
  always_ff @(posedge clk) begin
    status_r     <= status_nxt;
    idx_r        <= idx_nxt;
    head_r       <= head_nxt;
    carry_r      <= carry_nxt;
    popped_r     <= popped_nxt;
    out_data_r   <= out_data_nxt;
    out_status_r <= out_status_nxt;
  end

  assign in_tready  = (state_r == sutq_pkg::S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_status_r;

endmodule

// ===== hdl/sutq_ram.sv =====
// generic single write, single read ram with registered read data
module sutq_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== dv/tb_sorted_unique_timestamp_queue_top.sv =====
// self-checking testbench of the sorted unique timestamp queue, with a set predictor
module tb_sorted_unique_timestamp_queue_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CAP            = sutq_pkg::CAPACITY_DEF;
  localparam int unsigned RANDOM_ITEMS   = 1600;
  localparam int unsigned WATCHDOG_LIMIT = 4000;
  localparam int unsigned DRAIN_CYCLES   = CAP + 8;
  localparam int unsigned TS_W           = sutq_pkg::TS_W;
  localparam int unsigned COUNT_W        = sutq_pkg::COUNT_W;
  localparam int unsigned OUT_DATA_W     = sutq_pkg::OUT_DATA_W;

  typedef logic signed [TS_W-1:0] stamp_t;

  // one expected result item
  typedef struct {
    sutq_pkg::status_t    status;
    logic [TS_W-1:0]      popped;
    logic [TS_W-1:0]      head;
    logic                 empty;
    logic [COUNT_W-1:0]   count;
  } queue_result_t;

  // mirror of the ordered set and the queue of results still owed by the block
  class ts_set_scoreboard;
    stamp_t        held[$];
    queue_result_t owed[$];
    int unsigned   capacity;
    int unsigned   mismatches;
    int unsigned   checked;
    int unsigned   status_seen[8];

    function new(int unsigned cap);
      capacity   = cap;
      mismatches = 0;
      checked    = 0;
      foreach (status_seen[i]) status_seen[i] = 0;
    endfunction

    function int unsigned occupancy();
      return held.size();
    endfunction

    function int unsigned pending();
      return owed.size();
    endfunction

    // apply one accepted input item to the mirror and queue its result
    function void note_item(sutq_pkg::action_t act, stamp_t ts);
      queue_result_t r;
      int unsigned   slot;
      r.popped = '0;
      case (act)
        sutq_pkg::ACT_INSERT: begin
          // first entry not below the new value
          slot = held.size();
          for (int k = 0; k < held.size(); k++) begin
            if (held[k] >= ts) begin
              slot = k;
              break;
            end
          end
          if (slot < held.size() && held[slot] == ts) begin
            r.status = sutq_pkg::ST_DUPLICATE;
          end else if (held.size() >= capacity) begin
            r.status = sutq_pkg::ST_FULL;
          end else begin
            held.insert(slot, ts);
            r.status = sutq_pkg::ST_INSERTED;
          end
        end
        sutq_pkg::ACT_POP: begin
          if (held.size() == 0) begin
            r.status = sutq_pkg::ST_POP_EMPTY;
          end else begin
            r.popped = held.pop_front();
            r.status = sutq_pkg::ST_POPPED;
          end
        end
        default: begin
          // both clear codes empty the set
          held.delete();
          r.status = sutq_pkg::ST_CLEARED;
        end
      endcase
      r.head  = (held.size() != 0) ? held[0] : '0;
      r.empty = (held.size() == 0);
      r.count = COUNT_W'(held.size());
      owed.push_back(r);
    endfunction

    function void compare_field(string field, logic [TS_W-1:0] want,
                                logic [TS_W-1:0] got);
      if (want !== got) begin
        if (mismatches < 10)
          $display("[%0t] mismatch on %s after %0d results: expected %h, got %h",
                   $realtime, field, checked, want, got);
        mismatches++;
      end
    endfunction

    // compare one result item against the oldest expectation
    function void check_result(logic [sutq_pkg::STATUS_W-1:0] st,
                               logic [OUT_DATA_W-1:0] data);
      queue_result_t r;
      if (owed.size() == 0) begin
        if (mismatches < 10)
          $display("[%0t] result with nothing outstanding: status %0d, data %h",
                   $realtime, st, data);
        mismatches++;
        return;
      end
      r = owed.pop_front();
      checked++;
      status_seen[r.status]++;
      compare_field("status", TS_W'(r.status), TS_W'(st));
      compare_field("popped_value", r.popped, data[TS_W-1:0]);
      compare_field("head_value", r.head, data[2*TS_W-1:TS_W]);
      compare_field("set_empty", TS_W'(r.empty), TS_W'(data[2*TS_W]));
      compare_field("entry_count", TS_W'(r.count),
                    TS_W'(data[2*TS_W+COUNT_W:2*TS_W+1]));
      compare_field("padding", '0,
                    TS_W'(data[OUT_DATA_W-1:sutq_pkg::OUT_FIELDS_W]));
    endfunction
  endclass

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [TS_W-1:0]       in_tdata;    // timestamp[63:0]
  logic [sutq_pkg::ACTION_W-1:0] in_tuser;    // action[1:0]
  logic                  out_tvalid;
  logic                  out_tready;
  // popped_value[63:0], head_value[127:64], set_empty[128],
  // entry_count[133:129], zero[135:134]
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [sutq_pkg::STATUS_W-1:0] out_tuser;   // status[2:0]

  ts_set_scoreboard sb = new(CAP);

  int unsigned items_sent  = 0;
  int unsigned burst_left  = 0;
  int unsigned idle_cycles = 0;
  int unsigned ready_phase = 0;
  logic [15:0] ready_pattern = 16'hffff;

  sorted_unique_timestamp_queue_top #(
    .CAPACITY(CAP)
  ) uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // receiver stalls follow a rotating 16-bit pattern, which is renewed with a random or an all-ones value
  always @(negedge clk) begin
    if (ready_phase % 64 == 63) begin
      if ($urandom_range(0, 3) == 0)
        ready_pattern <= 16'hffff;
      else
        ready_pattern <= 16'($urandom) | 16'h0001;
    end
    out_tready  <= rst_n & ready_pattern[ready_phase % 16];
    ready_phase <= ready_phase + 1;
  end

  // result checking at the rising edge
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      sb.check_result(out_tuser, out_tdata);
  end

  // watchdog on cycles with no item moving on either side
  initial begin
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || !rst_n)
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("[%0t] no item moved for %0d cycles", $realtime, WATCHDOG_LIMIT);
    $display("Some tests failed");
    $finish;
  end

  // send one item, with bursts separated by random gaps
  task automatic send_item(sutq_pkg::action_t act, stamp_t ts);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = $urandom_range(1, 12);
      @(negedge clk);
      in_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
      burst_left = $urandom_range(1, 30);
    end
    burst_left--;
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata  <= ts;
    in_tuser  <= act;
    do @(posedge clk); while (!in_tready);
    sb.note_item(act, ts);
    items_sent++;
  endtask

  // timestamps: a narrow band for duplicates, neighbours of held entries,
  // extremes, anything
  function automatic stamp_t random_stamp();
    stamp_t      v;
    int unsigned n;
    n = sb.occupancy();
    case ($urandom_range(0, 9))
      0, 1, 2: v = stamp_t'($urandom_range(0, 40)) - 20;
      3: begin
        case ($urandom_range(0, 3))
          0:       v = {1'b1, {(TS_W-1){1'b0}}};
          1:       v = {1'b0, {(TS_W-1){1'b1}}};
          2:       v = '0;
          default: v = '1;
        endcase
      end
      4, 5: begin
        if (n != 0)
          v = sb.held[$urandom_range(0, n - 1)] + stamp_t'($urandom_range(0, 2)) - 1;
        else
          v = {$urandom, $urandom};
      end
      default: v = {$urandom, $urandom};
    endcase
    return v;
  endfunction

  function automatic sutq_pkg::action_t random_action();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return sutq_pkg::ACT_INSERT;
    if (r < 90) return sutq_pkg::ACT_POP;
    if (r < 95) return sutq_pkg::ACT_CLEAR;
    return sutq_pkg::ACT_CLEAR2;
  endfunction

  // stimulus and end of run
  initial begin
    int unsigned kind;
    int unsigned tries;
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    in_tuser   = sutq_pkg::ACT_INSERT;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;

    // directed: empty pop, alternate clear code, extremes, duplicate, pop of minimum
    send_item(sutq_pkg::ACT_POP, '1);
    send_item(sutq_pkg::ACT_CLEAR2, {1'b1, {(TS_W-1){1'b0}}});
    send_item(sutq_pkg::ACT_INSERT, {1'b0, {(TS_W-1){1'b1}}});
    send_item(sutq_pkg::ACT_INSERT, {1'b1, {(TS_W-1){1'b0}}});
    send_item(sutq_pkg::ACT_INSERT, '0);
    send_item(sutq_pkg::ACT_INSERT, '1);
    send_item(sutq_pkg::ACT_INSERT, {1'b0, {(TS_W-1){1'b1}}});
    send_item(sutq_pkg::ACT_POP, 64'h5555_5555_5555_5555);
    // fill to capacity, then a new value is dropped and a held one is a duplicate
    for (int k = 1; k <= CAP - 3; k++)
      send_item(sutq_pkg::ACT_INSERT, stamp_t'(k * 1000));
    send_item(sutq_pkg::ACT_INSERT, 64'h5555_5555_5555_5555);
    send_item(sutq_pkg::ACT_INSERT, '0);
    send_item(sutq_pkg::ACT_CLEAR, 64'haaaa_aaaa_aaaa_aaaa);

    // random episodes: fills past capacity, full drains, mixed traffic, clears
    while (items_sent < RANDOM_ITEMS) begin
      kind = $urandom_range(0, 9);
      if (kind < 4) begin
        tries = 0;
        while (sb.occupancy() < CAP && tries < 4 * CAP) begin
          send_item(sutq_pkg::ACT_INSERT, random_stamp());
          tries++;
        end
        repeat ($urandom_range(1, 3)) send_item(sutq_pkg::ACT_INSERT, random_stamp());
      end else if (kind < 6) begin
        while (sb.occupancy() != 0)
          send_item(sutq_pkg::ACT_POP, {$urandom, $urandom});
        repeat ($urandom_range(0, 2)) send_item(sutq_pkg::ACT_POP, {$urandom, $urandom});
      end else if (kind < 9) begin
        repeat ($urandom_range(10, 40)) send_item(random_action(), random_stamp());
      end else begin
        send_item(($urandom_range(0, 1) != 0) ? sutq_pkg::ACT_CLEAR : sutq_pkg::ACT_CLEAR2,
                  {$urandom, $urandom});
      end
    end

    @(negedge clk);
    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("run covered %0d items and %0d results: %0d inserted, %0d duplicates,",
             items_sent, sb.checked, sb.status_seen[sutq_pkg::ST_INSERTED],
             sb.status_seen[sutq_pkg::ST_DUPLICATE]);
    $display("  %0d full drops, %0d pops, %0d pops on an empty set, %0d clears, %0d mismatches",
             sb.status_seen[sutq_pkg::ST_FULL], sb.status_seen[sutq_pkg::ST_POPPED],
             sb.status_seen[sutq_pkg::ST_POP_EMPTY], sb.status_seen[sutq_pkg::ST_CLEARED],
             sb.mismatches);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
